// ===== rtl/core/turing_machine_step_top_macros.svh =====
// ----------------------------------------------------------------------------
// turing machine step assertion macros
// concurrent checks on a clock with a synchronous active-high reset
// ----------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEP_TOP_MACROS_SVH
`define TURING_MACHINE_STEP_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// condition implies consequence in the same cycle
`define TMS_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define TMS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define TMS_ASSERT_IMPLY(label, clk, rst, cond, cons)
`define TMS_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ===== rtl/core/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// shared types and constants of the turing machine step engine
// ----------------------------------------------------------------------------
package tms_pkg;

   // action codes of a request word
   localparam logic [2:0] ACT_LOAD_RULE = 3'd0;
   localparam logic [2:0] ACT_LOAD_TAPE = 3'd1;
   localparam logic [2:0] ACT_START     = 3'd2;
   localparam logic [2:0] ACT_STEP      = 3'd3;
   localparam logic [2:0] ACT_READ_TAPE = 3'd4;

   // state character that halts the machine ('!')
   localparam logic [7:0] HALT_CHAR = 8'd33;

   // width of the rule count register
   localparam int CFG_W = 8;

   // request word
   typedef struct packed {
      logic [2:0] action;
      logic [6:0] rule_index;
      logic [7:0] rule_state;
      logic [7:0] rule_symbol;
      logic [7:0] rule_write;
      logic       rule_move_right;
      logic [7:0] rule_next;
      logic [9:0] tape_address;
      logic [7:0] tape_data;
   } tms_req_type;

   // response word
   typedef struct packed {
      logic [7:0] state_now;
      logic [9:0] head_now;
      logic       halted;
      logic [7:0] data_out;
   } tms_rsp_type;

   // one rule table entry
   typedef struct packed {
      logic [7:0] state;
      logic [7:0] symbol;
      logic [7:0] write;
      logic       move_right;
      logic [7:0] next;
   } tms_rule_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic wrap_step;
      logic clr_wr;
      logic cnt_clr;
      logic cnt_inc;
      logic rule_wr;
      logic tape_load;
      logic rule_rd_zero;
      logic tape_rd_addr;
      logic rule_rd_srch;
      logic start_set;
      logic read_set;
      logic apply;
   } tms_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic       wrap_done;
      logic       clear_last;
      logic       srch_last;
      logic       halted;
   } tms_sts_type;

endpackage

// ===== rtl/core/tms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tms_ctrl
// sequencer of the turing machine step engine: tape clear, address wrap,
// rule search and the single-cycle result strobe
// ----------------------------------------------------------------------------
module tms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output tms_pkg::tms_cmd_type cmd,
   input  tms_pkg::tms_sts_type sts
);

   // state codes
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_WRAP  = 4'd2;
   localparam logic [3:0] ST_EXEC  = 4'd3;
   localparam logic [3:0] ST_MEMRD = 4'd4;
   localparam logic [3:0] ST_FIN   = 4'd5;
   localparam logic [3:0] ST_SRCH  = 4'd6;
   localparam logic [3:0] ST_DRAIN = 4'd7;
   localparam logic [3:0] ST_APPLY = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // handshake outputs
   assign busy       = !((state_ff == ST_IDLE) || (state_ff == ST_RESP));
   assign rsp_strobe = (state_ff == ST_RESP);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_RESP: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_WRAP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WRAP: begin
            cmd.wrap_step = 1'b1;
            if (sts.wrap_done) begin
               case (sts.action)
                  tms_pkg::ACT_LOAD_RULE, tms_pkg::ACT_LOAD_TAPE: begin
                     state_in = ST_EXEC;
                  end
                  tms_pkg::ACT_START, tms_pkg::ACT_READ_TAPE: begin
                     state_in = ST_MEMRD;
                  end
                  tms_pkg::ACT_STEP: begin
                     if (sts.halted) begin
                        state_in = ST_RESP;
                     end else begin
                        cmd.cnt_clr = 1'b1;
                        state_in    = ST_SRCH;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            cmd.rule_wr   = (sts.action == tms_pkg::ACT_LOAD_RULE);
            cmd.tape_load = (sts.action == tms_pkg::ACT_LOAD_TAPE);
            state_in      = ST_RESP;
         end
         ST_MEMRD: begin
            cmd.rule_rd_zero = 1'b1;
            cmd.tape_rd_addr = 1'b1;
            state_in         = ST_FIN;
         end
         ST_FIN: begin
            cmd.start_set = (sts.action == tms_pkg::ACT_START);
            cmd.read_set  = (sts.action == tms_pkg::ACT_READ_TAPE);
            state_in      = ST_RESP;
         end
         ST_SRCH: begin
            cmd.rule_rd_srch = 1'b1;
            cmd.cnt_inc      = 1'b1;
            if (sts.srch_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register, reset starts the tape clear
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tms_dpath.sv =====
// ----------------------------------------------------------------------------
// tms_dpath
// rule table, tape memory, machine registers, address wrap and rule compare
// ----------------------------------------------------------------------------
module tms_dpath #(
   parameter int RULE_DEPTH = 128,
   parameter int TAPE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tms_pkg::tms_req_type          req_data,
   input  logic                          csr_we,
   input  logic [tms_pkg::CFG_W-1:0]     csr_data,
   input  tms_pkg::tms_cmd_type          cmd,
   output tms_pkg::tms_sts_type          sts,
   output tms_pkg::tms_rsp_type          rsp_data
);

   // address and counter widths
   localparam int RA_W   = $clog2(RULE_DEPTH);
   localparam int TA_W   = $clog2(TAPE_DEPTH);
   localparam int RC_W   = $clog2(RULE_DEPTH + 1);
   localparam int RX_W   = (RC_W > 7) ? RC_W : 7;
   localparam int TC_W   = $clog2(TAPE_DEPTH + 1);
   localparam int TX_W   = (TC_W > 10) ? TC_W : 10;
   localparam int CNT_W  = (TA_W > RC_W) ? TA_W : RC_W;
   localparam int CMP_W0 = (CNT_W > tms_pkg::CFG_W) ? CNT_W : tms_pkg::CFG_W;
   localparam int CMP_W  = (CMP_W0 > RC_W) ? CMP_W0 : RC_W;

   // memories
   tms_pkg::tms_rule_type rule_mem [RULE_DEPTH];
   logic [7:0]            tape_mem [TAPE_DEPTH];

   // control registers
   logic [7:0]                state_ff;
   logic [TA_W-1:0]           head_ff;
   logic                      halt_ff;
   logic [tms_pkg::CFG_W-1:0] rule_count_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      cap_vld_ff;

   // payload registers
   tms_pkg::tms_req_type  req_ff;
   logic [RX_W-1:0]       ridx_ff;
   logic [TX_W-1:0]       taddr_ff;
   logic [7:0]            data_out_ff;
   tms_pkg::tms_rule_type rule_rd_ff;
   logic [7:0]            tape_rd_ff;
   logic                  cap_zero_ff;
   tms_pkg::tms_rule_type chosen_ff;

   logic [RA_W-1:0]  rule_ra;
   logic             tape_we;
   logic [TA_W-1:0]  tape_wa;
   logic [7:0]       tape_wd;
   logic [TA_W-1:0]  tape_ra;
   logic [TA_W-1:0]  head_in;
   logic [CMP_W-1:0] rc_ext;
   logic [CMP_W-1:0] lim;
   logic [CMP_W-1:0] last_idx;
   logic             ridx_hi;
   logic             taddr_hi;
   logic             cap_hit;
   logic [TX_W-1:0]  head_wide;

   tms_pkg::tms_rule_type rule_wd;

   // search limit: rule count capped at table depth, at least one entry read
   assign rc_ext   = CMP_W'(rule_count_ff);
   assign lim      = (rc_ext > CMP_W'(RULE_DEPTH)) ? CMP_W'(RULE_DEPTH) : rc_ext;
   assign last_idx = (lim == '0) ? '0 : lim - CMP_W'(1);

   // address wrap by repeated subtraction
   assign ridx_hi  = (ridx_ff >= RX_W'(RULE_DEPTH));
   assign taddr_hi = (taddr_ff >= TX_W'(TAPE_DEPTH));

   // status to the controller
   assign sts.action     = req_ff.action;
   assign sts.wrap_done  = !ridx_hi && !taddr_hi;
   assign sts.clear_last = (cnt_ff == CNT_W'(TAPE_DEPTH - 1));
   assign sts.srch_last  = (CMP_W'(cnt_ff) == last_idx);
   assign sts.halted     = halt_ff;

   // rule table write data
   always_comb begin
      rule_wd.state      = req_ff.rule_state;
      rule_wd.symbol     = req_ff.rule_symbol;
      rule_wd.write      = req_ff.rule_write;
      rule_wd.move_right = req_ff.rule_move_right;
      rule_wd.next       = req_ff.rule_next;
   end

   // rule table port
   assign rule_ra = cmd.rule_rd_zero ? '0 : cnt_ff[RA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rule_wr) begin
         rule_mem[ridx_ff[RA_W-1:0]] <= rule_wd;
      end
      rule_rd_ff <= rule_mem[rule_ra];
   end

   // tape port: clear sweep, load, or write-back under the head
   always_comb begin
      tape_we = cmd.clr_wr || cmd.tape_load || cmd.apply;
      tape_wa = head_ff;
      tape_wd = chosen_ff.write;
      if (cmd.clr_wr) begin
         tape_wa = cnt_ff[TA_W-1:0];
         tape_wd = '0;
      end else if (cmd.tape_load) begin
         tape_wa = taddr_ff[TA_W-1:0];
         tape_wd = req_ff.tape_data;
      end
   end

   assign tape_ra = cmd.tape_rd_addr ? taddr_ff[TA_W-1:0] : head_ff;

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
      tape_rd_ff <= tape_mem[tape_ra];
   end

   // request capture and address wrap
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff   <= req_data;
         ridx_ff  <= RX_W'(req_data.rule_index);
         taddr_ff <= TX_W'(req_data.tape_address);
      end else if (cmd.wrap_step) begin
         if (ridx_hi) begin
            ridx_ff <= ridx_ff - RX_W'(RULE_DEPTH);
         end
         if (taddr_hi) begin
            taddr_ff <= taddr_ff - TX_W'(TAPE_DEPTH);
         end
      end
   end

   // read data word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_out_ff <= '0;
      end else if (cmd.read_set) begin
         data_out_ff <= tape_rd_ff;
      end
   end

   // rule compare, one entry a cycle; entry zero is always taken as fallback
   assign cap_hit = cap_vld_ff && (cap_zero_ff ||
                    ((rule_rd_ff.state == state_ff) && (rule_rd_ff.symbol == tape_rd_ff)));

   always_ff @(posedge clock) begin
      cap_zero_ff <= (cnt_ff == '0);
      if (cap_hit) begin
         chosen_ff <= rule_rd_ff;
      end
   end

   // head move with wrap
   always_comb begin
      if (chosen_ff.move_right) begin
         head_in = (head_ff == TA_W'(TAPE_DEPTH - 1)) ? '0 : head_ff + TA_W'(1);
      end else begin
         head_in = (head_ff == '0) ? TA_W'(TAPE_DEPTH - 1) : head_ff - TA_W'(1);
      end
   end

   // machine registers, counter and rule count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         head_ff       <= '0;
         halt_ff       <= 1'b0;
         rule_count_ff <= '0;
         cnt_ff        <= '0;
         cap_vld_ff    <= 1'b0;
      end else begin
         cap_vld_ff <= cmd.rule_rd_srch;
         if (csr_we) begin
            rule_count_ff <= csr_data;
         end
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.start_set) begin
            state_ff <= rule_rd_ff.state;
            head_ff  <= '0;
            halt_ff  <= 1'b0;
         end else if (cmd.apply) begin
            state_ff <= chosen_ff.next;
            head_ff  <= head_in;
            if (chosen_ff.next == tms_pkg::HALT_CHAR) begin
               halt_ff <= 1'b1;
            end
         end
      end
   end

   // response word
   assign head_wide         = TX_W'(head_ff);
   assign rsp_data.state_now = state_ff;
   assign rsp_data.head_now  = head_wide[9:0];
   assign rsp_data.halted    = halt_ff;
   assign rsp_data.data_out  = data_out_ff;

endmodule

// ===== rtl/core/turing_machine_step_top.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step_top
// single-tape turing machine engine with loadable rules and tape
// ----------------------------------------------------------------------------
// usage
//   request: drive req_data and raise start; the word is taken at a clock
//   edge where start is high and busy is low. actions load a rule, load a
//   tape cell, start the machine, run one step or read a tape cell.
//   response: every request gives one word on rsp_data, marked by rsp_strobe
//   for exactly one cycle; the receiver cannot stall it.
//   config: rule_count is written on csr_data when csr_valid and csr_ready
//   are high; csr_ready is always high, write it only while idle.
// sequence
//   address wrap subtracts the depth while an address is at or above it,
//   needed only when the depth is below the field range. unknown actions
//   and a step while halted go wrap, response; loads go wrap, exec,
//   response; start and read tape go wrap, memory read, finish, response;
//   a step goes wrap, a rule search reading one table entry per cycle over
//   n = rule count capped at RULE_DEPTH (at least 1), drain, apply, response.
//   a new request may be taken in the cycle its predecessor's strobe is out.
// reset
//   clears state, head, halt flag and rule count, then sweeps the tape to
//   zero one cell per cycle, with busy high until the sweep is done.
// ----------------------------------------------------------------------------
`include "turing_machine_step_top_macros.svh"

module turing_machine_step_top #(
   parameter int RULE_DEPTH = 128,
   parameter int TAPE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tms_pkg::tms_req_type      req_data,
   output logic                      rsp_strobe,
   output tms_pkg::tms_rsp_type      rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tms_pkg::CFG_W-1:0] csr_data
);

   tms_pkg::tms_cmd_type cmd;
   tms_pkg::tms_sts_type sts;
   logic                 csr_we;
   logic                 rsp_halted;
   logic                 rsp_halt_char;

   // config channel is always open
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // sequencer
   tms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   // storage and compare
   tms_dpath #(
      .RULE_DEPTH (RULE_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // halted response word and halt state seen on the response
   assign rsp_halted    = rsp_strobe && rsp_data.halted;
   assign rsp_halt_char = (rsp_data.state_now == tms_pkg::HALT_CHAR);

   // checks
   `TMS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `TMS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TMS_ASSERT_IMPLY(a_halt_state, clock, reset, rsp_halted, rsp_halt_char)
   `TMS_ASSERT_IMPLY(a_strobe_not_busy, clock, reset, rsp_strobe, !busy)

endmodule
